FILE: design/edd4_pkg.sv
// Shared types, constants and divide-by-constant helpers for the four-level dither core.
package edd4_pkg;

  localparam int MAX_WIDTH    = 256;
  localparam int HEIGHT_LIMIT = 1024;
  localparam int ADDR_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
  localparam int ERR_W        = 6;
  localparam int PIX_W        = 8;
  localparam int FW_W         = 9;
  localparam int FH_W         = 11;
  localparam int CFG_W        = 11;
  localparam int CFG_IDX_W    = 1;
  localparam int OFIFO_DEPTH  = 3;
  localparam int OFIFO_PTR_W  = $clog2(OFIFO_DEPTH);
  localparam int OFIFO_CNT_W  = $clog2(OFIFO_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(178);
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(128);

  typedef logic [ADDR_W-1:0] col_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [ERR_W-1:0]  err_t;
  typedef logic [PIX_W-1:0]  pix_t;

  typedef struct packed {
    col_t x;
    logic x_gt0;
    logic y_gt0;
    logic ur_en;
    logic last_col;
    logic last_row;
  } pix_ctl_t;

  typedef struct packed {
    logic wr_en;
    col_t wr_addr;
    err_t wr_data;
    logic clr_en;
    col_t clr_addr;
  } lb_wr_t;

  typedef struct packed {
    pix_t gray;
    logic frame_end;
  } res_t;

  // Exact for every 6-bit value: floor(v * 43 / 128) equals floor(v / 3).
  function automatic logic [4:0] div3_err(input err_t v);
    logic [11:0] p;
    p = {6'b0, v} * 12'd43;
    return p[11:7];
  endfunction

  // Exact for every 6-bit value: floor(v * 13 / 64) equals floor(v / 5).
  function automatic logic [3:0] div5_err(input err_t v);
    logic [11:0] p;
    p = {6'b0, v} * 12'd13;
    return p[9:6];
  endfunction

endpackage

FILE: design/edd4_line_buf.sv
// Line buffer of pixel errors: one write port, two read ports, per-entry valid bits, forwarding.
module edd4_line_buf
  import edd4_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  col_t   rd_addr_a,
  input  col_t   rd_addr_b,
  input  lb_wr_t wr,
  output err_t   rd_data_a,
  output err_t   rd_data_b
);

  err_t                 mem [MAX_WIDTH];
  logic [MAX_WIDTH-1:0] vld_r;
  err_t                 raw_a_r;
  err_t                 raw_b_r;
  logic                 vld_a_r;
  logic                 vld_b_r;
  logic                 fwd_a_r;
  logic                 fwd_b_r;
  err_t                 fwd_d_a_r;
  err_t                 fwd_d_b_r;
  logic                 hit_wr_a;
  logic                 hit_wr_b;
  logic                 hit_clr_a;
  logic                 hit_clr_b;

  assign hit_wr_a  = wr.wr_en && (wr.wr_addr == rd_addr_a);
  assign hit_wr_b  = wr.wr_en && (wr.wr_addr == rd_addr_b);
  assign hit_clr_a = wr.clr_en && (wr.clr_addr == rd_addr_a);
  assign hit_clr_b = wr.clr_en && (wr.clr_addr == rd_addr_b);

  always_ff @(posedge clk) begin
    if (wr.wr_en) begin
      mem[wr.wr_addr] <= wr.wr_data;
    end
    raw_a_r <= mem[rd_addr_a];
    raw_b_r <= mem[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (wr.wr_en) begin
        vld_r[wr.wr_addr] <= 1'b1;
      end
      if (wr.clr_en) begin
        vld_r[wr.clr_addr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    vld_a_r   <= vld_r[rd_addr_a];
    vld_b_r   <= vld_r[rd_addr_b];
    fwd_a_r   <= hit_wr_a || hit_clr_a;
    fwd_b_r   <= hit_wr_b || hit_clr_b;
    fwd_d_a_r <= hit_wr_a ? wr.wr_data : '0;
    fwd_d_b_r <= hit_wr_b ? wr.wr_data : '0;
  end

  assign rd_data_a = fwd_a_r ? fwd_d_a_r : (vld_a_r ? raw_a_r : '0);
  assign rd_data_b = fwd_b_r ? fwd_d_b_r : (vld_b_r ? raw_b_r : '0);

endmodule

FILE: design/edd4_datapath.sv
// Error sum, saturation and quantization stage with the left and upper-left error registers.
module edd4_datapath
  import edd4_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     s2_valid,
  input  logic     fix_load,
  input  pix_ctl_t ctl,
  input  pix_t     pix,
  input  err_t     up_err,
  input  err_t     ur_err,
  output res_t     res,
  output lb_wr_t   lb_wr
);

  err_t       left_r;
  err_t       left_nxt;
  err_t       ul_r;
  logic [8:0] sum;
  pix_t       sat;
  logic [3:0] left_term;
  logic [4:0] up_term;
  logic [1:0] ul_term;
  logic [3:0] ur_term;

  always_comb begin
    left_term = ctl.x_gt0 ? left_r[ERR_W-1:2] : 4'd0;
    up_term   = (ctl.y_gt0 && !ctl.last_col) ? div3_err(up_err) : 5'd0;
    ul_term   = (ctl.y_gt0 && ctl.x_gt0) ? ul_r[ERR_W-1:4] : 2'd0;
    ur_term   = (ctl.y_gt0 && ctl.ur_en) ? div5_err(ur_err) : 4'd0;
    sum       = {1'b0, pix} + {5'd0, left_term} + {4'd0, up_term}
              + {7'd0, ul_term} + {5'd0, ur_term};
    sat       = sum[8] ? 8'hFF : sum[7:0];
  end

  always_comb begin
    if (ctl.last_col || ctl.last_row) begin
      res.gray = sat;
      left_nxt = '0;
    end else begin
      res.gray = {sat[7:6], 6'd0};
      left_nxt = sat[ERR_W-1:0];
    end
    res.frame_end = ctl.last_col && ctl.last_row;
  end

  always_comb begin
    lb_wr.wr_en    = s2_valid && ctl.x_gt0;
    lb_wr.wr_addr  = ctl.x - col_t'(1);
    lb_wr.wr_data  = left_r;
    lb_wr.clr_en   = s2_valid && ctl.last_col;
    lb_wr.clr_addr = ctl.x;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (s2_valid) begin
      left_r <= ctl.last_col ? '0 : left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid || fix_load) begin
      ul_r <= up_err;
    end
  end

endmodule

FILE: design/edd4_out_fifo.sv
// Three-entry result queue that decouples the pipeline from the output stall.
module edd4_out_fifo
  import edd4_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  res_t                   push_data,
  input  logic                   pop,
  output logic                   not_empty,
  output res_t                   head,
  output logic [OFIFO_CNT_W-1:0] count
);

  res_t                   q_r [OFIFO_DEPTH];
  logic [OFIFO_PTR_W-1:0] wr_ptr_r;
  logic [OFIFO_PTR_W-1:0] rd_ptr_r;
  logic [OFIFO_CNT_W-1:0] cnt_r;

  function automatic logic [OFIFO_PTR_W-1:0] ptr_inc(input logic [OFIFO_PTR_W-1:0] p);
    return (p == OFIFO_PTR_W'(OFIFO_DEPTH - 1)) ? '0 : p + OFIFO_PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      cnt_r <= cnt_r + OFIFO_CNT_W'(push) - OFIFO_CNT_W'(pop);
    end
  end

  assign not_empty = (cnt_r != '0);
  assign head      = q_r[rd_ptr_r];
  assign count     = cnt_r;

endmodule

FILE: design/error_diffusion_dither_4level_core.sv
// Top level of the four-level error-diffusion dither core: counters, config and pipeline control.
//
//   Channel | Ports                                  | Moves
//   --------+----------------------------------------+---------------------------------
//   in      | in_valid, in_stall, in_gray_in         | one gray pixel per request
//   out     | out_valid, out_stall, out_gray_out,    | one dithered pixel per request
//           | out_frame_end                          |
//   cfg     | cfg_we, cfg_index, cfg_wdata           | frame width (0), frame height (1)
//
// One pixel per cycle while in_stall is low; an accepted pixel passes the stage-2 registers and
// the output queue before it appears at the output. The line buffer is read at accept and
// read-modified-written in the cycle after. The first pixel after a width change that moves the
// column past the new row end is stalled (clamp, then fix_r) while the upper-left error is fetched.
// Reset is synchronous and takes effect immediately; the line buffer needs no clearing pass.
// The three-entry output queue absorbs stalls; input stalls once it would overflow, and also in reset, clamp and fix_r.
module error_diffusion_dither_4level_core
  import edd4_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     in_gray_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PIX_W-1:0]     out_gray_out,
  output logic                 out_frame_end,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [FW_W-1:0]        frame_width_r;
  logic [FH_W-1:0]        frame_height_r;
  col_t                   col_r;
  row_t                   row_r;
  logic                   fix_r;
  logic                   s2_valid_r;
  pix_ctl_t               s2_ctl_r;
  pix_t                   s2_pix_r;
  logic [FW_W-1:0]        fw_c;
  logic [FH_W-1:0]        fh_c;
  col_t                   wm1;
  row_t                   hm1;
  logic                   clamp;
  col_t                   x;
  row_t                   y;
  pix_ctl_t               ctl;
  logic                   accept;
  col_t                   rd_addr_a;
  col_t                   rd_addr_b;
  err_t                   up_err;
  err_t                   ur_err;
  res_t                   res;
  res_t                   head;
  lb_wr_t                 lb_wr;
  logic                   pop;
  logic [OFIFO_CNT_W-1:0] fifo_count;
  logic [OFIFO_CNT_W:0]   in_flight;

  always_comb begin
    if (frame_width_r < FW_W'(2)) begin
      fw_c = FW_W'(2);
    end else if (frame_width_r > FW_W'(MAX_WIDTH)) begin
      fw_c = FW_W'(MAX_WIDTH);
    end else begin
      fw_c = frame_width_r;
    end
    if (frame_height_r < FH_W'(2)) begin
      fh_c = FH_W'(2);
    end else if (frame_height_r > FH_W'(HEIGHT_LIMIT)) begin
      fh_c = FH_W'(HEIGHT_LIMIT);
    end else begin
      fh_c = frame_height_r;
    end
    wm1 = ADDR_W'(fw_c - FW_W'(1));
    hm1 = ROW_W'(fh_c - FH_W'(1));
  end

  always_comb begin
    clamp        = (col_r > wm1);
    x            = clamp ? wm1 : col_r;
    y            = (row_r >= hm1) ? hm1 : row_r;
    ctl.x        = x;
    ctl.x_gt0    = (x != '0);
    ctl.y_gt0    = (y != '0);
    ctl.ur_en    = ({1'b0, x} + (ADDR_W + 1)'(1)) < {1'b0, wm1};
    ctl.last_col = (x == wm1);
    ctl.last_row = (y == hm1);
    rd_addr_a    = clamp ? wm1 - col_t'(1) : x;
    rd_addr_b    = x + col_t'(1);
  end

  assign in_flight = {1'b0, fifo_count} + (OFIFO_CNT_W + 1)'(s2_valid_r);
  assign in_stall  = !rst_n || clamp || fix_r
                  || (in_flight >= (OFIFO_CNT_W + 1)'(OFIFO_DEPTH));
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      fix_r      <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      fix_r      <= clamp && !fix_r;
      s2_valid_r <= accept;
      if (accept) begin
        if (ctl.last_col) begin
          col_r <= '0;
          row_r <= ctl.last_row ? '0 : y + row_t'(1);
        end else begin
          col_r <= x + col_t'(1);
          row_r <= y;
        end
      end else if (fix_r) begin
        col_r <= wm1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_ctl_r <= ctl;
      s2_pix_r <= in_gray_in;
    end
  end

  edd4_line_buf u_line_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .wr        (lb_wr),
    .rd_data_a (up_err),
    .rd_data_b (ur_err)
  );

  edd4_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .s2_valid (s2_valid_r),
    .fix_load (fix_r),
    .ctl      (s2_ctl_r),
    .pix      (s2_pix_r),
    .up_err   (up_err),
    .ur_err   (ur_err),
    .res      (res),
    .lb_wr    (lb_wr)
  );

  assign pop = out_valid && !out_stall;

  edd4_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s2_valid_r),
    .push_data (res),
    .pop       (pop),
    .not_empty (out_valid),
    .head      (head),
    .count     (fifo_count)
  );

  assign out_gray_out  = head.gray;
  assign out_frame_end = head.frame_end;

endmodule

FILE: design/edd4_checker.sv
// Port-level checker for the dither core and its bind to the top level.
module edd4_checker
  import edd4_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [PIX_W-1:0] out_gray_out,
  input logic             out_frame_end
);

  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Output valid after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_gray_out) && $stable(out_frame_end))
    else $error("Stalled output request changed.");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> ##1 out_valid)
    else $error("Accepted pixel did not reach the output in two cycles.");

endmodule

bind error_diffusion_dither_4level_core edd4_checker u_edd4_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_gray_out  (out_gray_out),
  .out_frame_end (out_frame_end)
);

FILE: tb/sv/error_diffusion_dither_4level_core_checker.sv
`timescale 1ns / 1ps
// Checker for the four-level dither core: predicts every pixel and compares the output requests.
module error_diffusion_dither_4level_core_checker
  import edd4_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [PIX_W-1:0]     in_gray_in,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [PIX_W-1:0]     out_gray_out,
  input  logic                 out_frame_end,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   failures,
  output int                   outstanding
);

  localparam pix_t LEVEL_MASK = 8'hC0;

  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;
  err_t            line_err [MAX_WIDTH];
  err_t            left_err;
  int unsigned     col_pos;
  int unsigned     row_pos;
  res_t            dithered_q [$];

  function automatic res_t dither_pixel(input pix_t gray);
    int unsigned w, h, x, y, acc;
    logic        lc, lr;
    err_t        q_err;
    res_t        r;
    w = frame_width;
    if (w < 2) w = 2;
    else if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = frame_height;
    if (h < 2) h = 2;
    else if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
    x = (col_pos >= w - 1) ? w - 1 : col_pos;
    y = (row_pos >= h - 1) ? h - 1 : row_pos;
    lc = (x == w - 1);
    lr = (y == h - 1);

    acc = gray;
    if (x > 0) acc += left_err >> 2;
    if (y > 0) begin
      if (x < w - 1) acc += line_err[x] / 3;
      if (x > 0) acc += line_err[x - 1] >> 4;
      if (x + 1 < w - 1 && x + 1 < MAX_WIDTH) acc += line_err[x + 1] / 5;
    end
    if (acc > 255) acc = 255;

    if (lc || lr) begin
      r.gray = pix_t'(acc);
      q_err  = '0;
    end else begin
      r.gray = pix_t'(acc) & LEVEL_MASK;
      q_err  = err_t'(acc);
    end

    // The upper-left slot is read above before the delayed write lands in it.
    if (x > 0) line_err[x - 1] = left_err;
    if (lc) begin
      line_err[x] = '0;
      left_err    = '0;
    end else begin
      left_err = q_err;
    end

    r.frame_end = lc && lr;
    if (lc) begin
      col_pos = 0;
      row_pos = lr ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
      row_pos = y;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      frame_width  = FRAME_WIDTH_RST;
      frame_height = FRAME_HEIGHT_RST;
      for (int i = 0; i < MAX_WIDTH; i++) line_err[i] = '0;
      left_err = '0;
      col_pos  = 0;
      row_pos  = 0;
      dithered_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (dithered_q.size() == 0) begin
          $display("%0t: unexpected output request, expected none, actual gray_out=%0d frame_end=%0d",
                   $time, out_gray_out, out_frame_end);
          failures++;
        end else begin
          want = dithered_q.pop_front();
          if (out_gray_out !== want.gray) begin
            $display("%0t: gray_out expected %0d actual %0d", $time, want.gray, out_gray_out);
            failures++;
          end
          if (out_frame_end !== want.frame_end) begin
            $display("%0t: frame_end expected %0d actual %0d", $time, want.frame_end,
                     out_frame_end);
            failures++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_FRAME_WIDTH) frame_width = cfg_wdata[FW_W-1:0];
        else if (cfg_index == REG_FRAME_HEIGHT) frame_height = cfg_wdata[FH_W-1:0];
      end
      if (in_valid && !in_stall) dithered_q.push_back(dither_pixel(in_gray_in));
    end
    outstanding = dithered_q.size();
  end

endmodule

FILE: tb/sv/error_diffusion_dither_4level_core_test.sv
`timescale 1ns / 1ps
// Top of the dither core testbench: clock, reset, pixel stimulus, receiver stalls and verdict.
module error_diffusion_dither_4level_core_test;
  import edd4_pkg::*;

  localparam int RANDOM_PIXELS   = 1350;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int RUN_LIMIT_NS    = 4_000_000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [PIX_W-1:0]     in_gray_in;
  logic                 out_valid;
  logic                 out_stall;
  logic [PIX_W-1:0]     out_gray_out;
  logic                 out_frame_end;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   failures;
  int                   outstanding;
  logic                 hold_off_req = 1'b0;

  pix_t directed_pixels [25] = '{
    8'hFF, 8'h00, 8'h80,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'h3F, 8'h7F, 8'hBF, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'hFE,
    8'hFF, 8'h80, 8'h40, 8'h00
  };

  always #5 clk = ~clk;

  error_diffusion_dither_4level_core u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_gray_in    (in_gray_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_gray_out  (out_gray_out),
    .out_frame_end (out_frame_end),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  error_diffusion_dither_4level_core_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_gray_in    (in_gray_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_gray_out  (out_gray_out),
    .out_frame_end (out_frame_end),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .failures      (failures),
    .outstanding   (outstanding)
  );

  task automatic set_frame(input logic [CFG_W-1:0] width_val, input logic [CFG_W-1:0] height_val);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_wdata <= width_val;
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_wdata <= height_val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_pixel(input pix_t value);
    in_valid   <= 1'b1;
    in_gray_in <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_pixels(input int count);
    int remaining, burst, roll;
    remaining = count;
    while (remaining > 0) begin
      burst = $urandom_range(1, 32);
      while (burst > 0 && remaining > 0) begin
        roll = $urandom_range(0, 7);
        send_pixel(roll == 0 ? 8'hFF : roll == 1 ? 8'h00 : pix_t'($urandom_range(0, 255)));
        burst--;
        remaining--;
      end
      if (remaining > 0 && $urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int pct, run;
    bit hold_done;
    pct       = 0;
    run       = 0;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req && !hold_done) begin
        repeat (HOLD_OFF_CYCLES) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
        hold_done = 1'b1;
      end else begin
        if (run == 0) begin
          case ($urandom_range(0, 3))
            0: pct = 0;
            1: pct = $urandom_range(5, 30);
            2: pct = $urandom_range(30, 75);
            default: pct = 50;
          endcase
          run = $urandom_range(10, 60);
        end
        out_stall <= ($urandom_range(0, 99) < pct);
        run--;
        @(posedge clk);
      end
    end
  end

  initial begin
    int sent, phase, count;
    logic [CFG_W-1:0] width_val, height_val;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_gray_in <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_FRAME_WIDTH;
    cfg_wdata  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset geometry first, then a 3x3 frame changed in mid-row, then widths and
    // heights below range that act as a 2x2 frame.
    for (int i = 0; i < 25; i++) begin
      if (i == 3) begin
        wait_idle();
        set_frame(11'd3, 11'd3);
      end else if (i == 21) begin
        wait_idle();
        set_frame(11'h600, 11'd1);
      end
      send_pixel(directed_pixels[i]);
    end
    wait_idle();

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_PIXELS) begin
      if (phase == 1) begin
        width_val  = 11'h100;
        height_val = 11'd2;
        count      = 300;
      end else if (phase == 4) begin
        width_val  = 11'd2;
        height_val = 11'h7FF;
        count      = 90;
      end else begin
        case ($urandom_range(0, 9))
          0: width_val = {2'($urandom), 9'($urandom_range(0, 1))};
          1: width_val = {2'($urandom), 9'($urandom_range(256, 511))};
          default: width_val = 11'($urandom_range(2, 12));
        endcase
        case ($urandom_range(0, 9))
          0: height_val = 11'($urandom_range(0, 1));
          1: height_val = 11'($urandom_range(1024, 2047));
          2: height_val = 11'd2;
          default: height_val = 11'($urandom_range(2, 8));
        endcase
        count = (phase == 3) ? 80 : $urandom_range(8, 90);
      end
      set_frame(width_val, height_val);
      if (phase == 3) hold_off_req = 1'b1;
      send_pixels(count);
      wait_idle();
      sent += count;
      phase++;
    end

    if (failures == 0 && outstanding == 0)
      $display("error_diffusion_dither_4level_core_test: PASS");
    else
      $display("error_diffusion_dither_4level_core_test: FAIL");
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("error_diffusion_dither_4level_core_test: FAIL");
    $finish;
  end

endmodule

FILE: files.f
design/edd4_pkg.sv
design/edd4_line_buf.sv
design/edd4_datapath.sv
design/edd4_out_fifo.sv
design/error_diffusion_dither_4level_core.sv
design/edd4_checker.sv
tb/sv/error_diffusion_dither_4level_core_checker.sv
tb/sv/error_diffusion_dither_4level_core_test.sv
